// File: rtl/mdf_pkg.sv
// Shared constants and types for the message identifier duplicate filter.
`timescale 1ns / 1ps

package mdf_pkg;

    // Number of entries the window keeps
    localparam int WINDOW_DEPTH = 1024;
    localparam int ADDR_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);

    localparam int ID_W    = 64;
    localparam int BYTES_W = 24;
    localparam int TALLY_W = 48;

    // Window entry: matchable flag and both identifier halves
    localparam int ENTRY_W = 1 + 2 * ID_W;

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [FILL_W-1:0]  t_fill;
    typedef logic [TALLY_W-1:0] t_tally;

    typedef struct packed {
        logic            matchable;
        logic [ID_W-1:0] upper;
        logic [ID_W-1:0] lower;
    } t_entry;

endpackage

// File: rtl/mdf_in_if.sv
// Input channel: one message descriptor word per handshake.
`timescale 1ns / 1ps

interface mdf_in_if;
    logic        valid;
    logic        ready;
    logic        id_present;
    logic [63:0] id_upper;
    logic [63:0] id_lower;
    logic [23:0] message_bytes;

    modport source (output valid, id_present, id_upper, id_lower, message_bytes,
                    input ready);
    modport sink   (input valid, id_present, id_upper, id_lower, message_bytes,
                    output ready);
endinterface

// File: rtl/mdf_out_if.sv
// Output channel: one filter verdict word per handshake.
`timescale 1ns / 1ps

interface mdf_out_if;
    logic        valid;
    logic        ready;
    logic        forward;
    logic        evicted;
    logic [47:0] forwarded_total;
    logic [47:0] forwarded_byte_total;

    modport source (output valid, forward, evicted, forwarded_total,
                    forwarded_byte_total, input ready);
    modport sink   (input valid, forward, evicted, forwarded_total,
                    forwarded_byte_total, output ready);
endinterface

// File: rtl/message_id_duplicate_filter.sv
// Top level of the message identifier duplicate filter.
`timescale 1ns / 1ps

// Each accepted word that carries an identifier is checked against the window of
// the last WINDOW_DEPTH forwarded messages, held in one RAM read one entry per
// cycle from the oldest on. A duplicate stops the scan at its match, and a
// message without an identifier, or one that meets an empty window, skips the
// scan. The single RAM read port sets this scan rate. The result sits in an
// output register, so a new word is accepted while the previous verdict waits.
// No clearing pass after reset: only the fill_level written entries are ever
// read.
module message_id_duplicate_filter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mdf_in_if.sink           i_in,
    mdf_out_if.source        o_out
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam mdf_pkg::t_addr LAST_ADDR = mdf_pkg::ADDR_W'(mdf_pkg::WINDOW_DEPTH - 1);
    localparam mdf_pkg::t_fill FULL      = mdf_pkg::FILL_W'(mdf_pkg::WINDOW_DEPTH);

    logic [1:0]              r_state, n_state;
    mdf_pkg::t_addr          r_oldest, n_oldest;
    mdf_pkg::t_fill          r_fill, n_fill;
    mdf_pkg::t_tally         r_msg_tally, n_msg_tally;
    mdf_pkg::t_tally         r_byte_tally, n_byte_tally;

    // latched item
    logic                    r_present;
    logic [mdf_pkg::ID_W-1:0]    r_upper, r_lower;
    logic [mdf_pkg::BYTES_W-1:0] r_bytes;

    // scan control
    mdf_pkg::t_addr          r_rd_addr, n_rd_addr;
    mdf_pkg::t_fill          r_issued, n_issued;
    logic                    r_rd_pend, n_rd_pend;
    logic                    r_dup, n_dup;

    // output register
    logic                    r_out_valid, n_out_valid;
    logic                    r_forward, r_evicted;
    mdf_pkg::t_tally         r_out_msg, r_out_bytes;

    logic                    accept, out_free, finish, hit, full;
    logic                    ram_re, ram_we;
    mdf_pkg::t_addr          wr_slot;
    logic [mdf_pkg::ADDR_W:0] slot_sum;
    mdf_pkg::t_entry         rd_entry, wr_entry;
    logic [mdf_pkg::ENTRY_W-1:0] rd_data;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign finish   = (r_state == ST_FINISH) && out_free;
    assign full     = (r_fill == FULL);
    assign rd_entry = mdf_pkg::t_entry'(rd_data);
    assign hit      = r_rd_pend && rd_entry.matchable
                      && (rd_entry.upper == r_upper) && (rd_entry.lower == r_lower);

    // insert slot: oldest when full, else oldest + fill with one wrap
    assign slot_sum = {1'b0, r_oldest} + {1'b0, r_fill[mdf_pkg::ADDR_W-1:0]};
    always_comb begin
        if (full) begin
            wr_slot = r_oldest;
        end else if (slot_sum >= (mdf_pkg::ADDR_W+1)'(mdf_pkg::WINDOW_DEPTH)) begin
            wr_slot = mdf_pkg::ADDR_W'(slot_sum - (mdf_pkg::ADDR_W+1)'(mdf_pkg::WINDOW_DEPTH));
        end else begin
            wr_slot = slot_sum[mdf_pkg::ADDR_W-1:0];
        end
    end

    assign wr_entry.matchable = r_present;
    assign wr_entry.upper     = r_present ? r_upper : '0;
    assign wr_entry.lower     = r_present ? r_lower : '0;

    assign ram_we = finish && !r_dup;
    assign ram_re = (r_state == ST_SCAN) && !hit && (r_issued != r_fill);

    mdf_ram #(
        .DATA_W (mdf_pkg::ENTRY_W),
        .DEPTH  (mdf_pkg::WINDOW_DEPTH),
        .ADDR_W (mdf_pkg::ADDR_W)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_slot),
        .i_wdata (wr_entry),
        .i_re    (ram_re),
        .i_raddr (r_rd_addr),
        .o_rdata (rd_data)
    );

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_rd_addr    = r_rd_addr;
        n_issued     = r_issued;
        n_rd_pend    = 1'b0;
        n_dup        = r_dup;
        n_oldest     = r_oldest;
        n_fill       = r_fill;
        n_msg_tally  = r_msg_tally;
        n_byte_tally = r_byte_tally;
        n_out_valid  = r_out_valid && !o_out.ready;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_rd_addr = r_oldest;
                    n_issued  = '0;
                    n_dup     = 1'b0;
                    n_state   = (i_in.id_present && r_fill != '0) ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    n_dup   = 1'b1;
                    n_state = ST_FINISH;
                end else if (r_issued == r_fill) begin
                    n_state = ST_FINISH;
                end else begin
                    n_rd_addr = (r_rd_addr == LAST_ADDR) ? '0 : r_rd_addr + 1'b1;
                    n_issued  = r_issued + 1'b1;
                    n_rd_pend = 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    if (!r_dup) begin
                        n_msg_tally  = r_msg_tally + 1'b1;
                        n_byte_tally = r_byte_tally + mdf_pkg::TALLY_W'(r_bytes);
                        if (full) begin
                            n_oldest = (r_oldest == LAST_ADDR) ? '0 : r_oldest + 1'b1;
                        end else begin
                            n_fill = r_fill + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_oldest     <= '0;
            r_fill       <= '0;
            r_msg_tally  <= '0;
            r_byte_tally <= '0;
            r_rd_pend    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_oldest     <= n_oldest;
            r_fill       <= n_fill;
            r_msg_tally  <= n_msg_tally;
            r_byte_tally <= n_byte_tally;
            r_rd_pend    <= n_rd_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_addr <= n_rd_addr;
        r_issued  <= n_issued;
        r_dup     <= n_dup;
        if (accept) begin
            r_present <= i_in.id_present;
            r_upper   <= i_in.id_upper;
            r_lower   <= i_in.id_lower;
            r_bytes   <= i_in.message_bytes;
        end
        if (finish) begin
            r_forward   <= !r_dup;
            r_evicted   <= !r_dup && full;
            r_out_msg   <= n_msg_tally;
            r_out_bytes <= n_byte_tally;
        end
    end

    assign i_in.ready                 = (r_state == ST_IDLE);
    assign o_out.valid                = r_out_valid;
    assign o_out.forward              = r_forward;
    assign o_out.evicted              = r_evicted;
    assign o_out.forwarded_total      = r_out_msg;
    assign o_out.forwarded_byte_total = r_out_bytes;

    // checks
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL) else $error("fill level beyond window depth");

    a_oldest_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oldest != '0) |-> full) else $error("oldest pointer moved before window full");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != ST_IDLE)) else $error("accepted word not processed");

    a_scan_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_issued <= r_fill)) else $error("scan past fill level");

endmodule

// File: rtl/mdf_ram.sv
// Simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps

module mdf_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered, enabled by i_re
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
